>>> sv/wts_pkg.sv
// ----------------------------------------------------------------------------
// wts_pkg: shared types and constants for the weighted trend slope block
// Holds field widths, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package wts_pkg;

    localparam int MAX_HISTORY_DEF = 6;
    localparam int VAL_W  = 32;
    localparam int TIME_W = 32;
    localparam int SCL_W  = 17;
    localparam int WGT_W  = 16;
    localparam int RATE_W = 48;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 3;

    // Wide accumulator: num/den up to ~2^(32+32+33+15 + 4) and scaled by 3600*2^17.
    localparam int ACC_W  = 160;
    localparam int QUO_W  = 160;

    localparam logic [IDX_W-1:0] REG_CLAMP  = 3'd0;
    localparam logic [IDX_W-1:0] REG_COUNT  = 3'd1;
    localparam logic [IDX_W-1:0] REG_W0     = 3'd2;

    localparam logic [11:0] HOUR_SECONDS = 12'd3600;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_PAIR,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_ACC,
        ST_PREP,
        ST_SC1,
        ST_SC2,
        ST_DSTART,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

>>> sv/wts_divider.sv
// ----------------------------------------------------------------------------
// wts_divider: restoring divider, one quotient bit per cycle
// Divides an unsigned dividend by an unsigned nonzero divisor.
// ----------------------------------------------------------------------------
module wts_divider
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [wts_pkg::ACC_W-1:0] dividend,
    input  logic [wts_pkg::ACC_W-1:0] divisor,
    output logic                      done,
    output logic [wts_pkg::QUO_W-1:0] quotient
);
    import wts_pkg::*;

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [ACC_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [ACC_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [ACC_W:0]   shifted;
    logic [ACC_W:0]   diff;

    // Shift in one dividend bit and try a subtract
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[QUO_W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(QUO_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[ACC_W])
            begin
                rem_next = diff[ACC_W-1:0];
                quo_next = {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[ACC_W-1:0];
                quo_next = {quo_reg[QUO_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    // Count never exceeds the quotient width
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(QUO_W)) else $error("divider count out of range");
    // Done only ends a busy run
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg) else $error("divider done while busy");
    // Busy drops only with done
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> done_reg) else $error("divider stopped without done");

endmodule

>>> sv/weighted_trend_slope.sv
// ----------------------------------------------------------------------------
// weighted_trend_slope: weighted least-squares slope of a sample history
// Stores up to MAX_HISTORY samples, then forms the slope per hour, scaled.
// ----------------------------------------------------------------------------
// Usage: samples arrive on the input channel newest first (valid/stall).
// A sample without is_last is taken and stall stays low. On is_last the
// block raises stall while it works: each pair of kept samples passes
// through ST_PAIR, ST_M1, ST_M2, ST_M3 and ST_ACC on a shared 33x32
// multiplier and a second partial product (up to 15 pairs). A degenerate,
// balanced or clamped series then loads its result from ST_PREP;
// a single sample loads a degenerate result directly. Otherwise ST_SC1
// forms 3600*scale, ST_SC2 scales the numerator one 32-bit limb at a time,
// ST_DSTART starts the restoring divider, and the result is loaded when
// the divider is done. The result sits in an output register; while the
// receiver stalls it holds and the input stays stalled. The next item is
// taken after the result is taken, once the block is back in ST_LOAD.
// Reset clears the sample count, restores register defaults and empties
// the output. Configuration writes are taken on any cycle with cfg_we high.
// ----------------------------------------------------------------------------
module weighted_trend_slope
#(
    parameter int MAX_HISTORY = wts_pkg::MAX_HISTORY_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [wts_pkg::IDX_W-1:0]           cfg_index,
    input  logic [wts_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [wts_pkg::VAL_W-1:0]    sample_value,
    input  logic [wts_pkg::TIME_W-1:0]          sample_time,
    input  logic [wts_pkg::SCL_W-1:0]           scale_factor,
    input  logic                                is_last,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [wts_pkg::RATE_W-1:0]   rate_per_hour,
    output logic                                degenerate,
    output logic                                saturated
);
    import wts_pkg::*;

    localparam int SLOT_W = $clog2(MAX_HISTORY);
    localparam int CNT_W  = $clog2(MAX_HISTORY + 1);
    localparam int LIMB_N = ACC_W / 32;

    // Configuration registers
    logic [1:0]       clamp_reg;
    logic [2:0]       wcount_reg;
    logic [WGT_W-1:0] weight_reg [6];

    // Sample stores
    logic [VAL_W-1:0]  value_store [MAX_HISTORY];
    logic [TIME_W-1:0] time_store  [MAX_HISTORY];
    logic [CNT_W-1:0]  count_reg, count_next;

    state_t state_reg, state_next;
    logic [SLOT_W-1:0] i_reg, i_next, j_reg, j_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [2:0]        limb_reg, limb_next;
    logic [SCL_W-1:0]  scale_reg;

    // Pair terms
    logic [32:0]        adx_reg, ady_reg;
    logic               pneg_reg, pzero_reg;
    logic [31:0]        wp_reg;
    logic [ACC_W-1:0]   prod_reg;
    logic [ACC_W-1:0]   tden_reg;
    logic [ACC_W-1:0]   pos_reg, neg_reg, den_reg;
    logic [ACC_W-1:0]   divd_reg;
    logic               negr_reg;

    // Output register
    logic                out_valid_reg;
    logic [RATE_W-1:0]   rate_reg;
    logic                degen_reg, sat_reg;

    logic [CNT_W-1:0] eff;
    logic             accept;
    logic             div_start, div_done;
    logic [QUO_W-1:0] quotient;

    // Shared multiplier: 33 x 32 feeding a wide partial-product shift
    logic [32:0]       mul_a;
    logic [31:0]       mul_b;
    logic [64:0]       mul_p;
    assign mul_p = {32'd0, mul_a} * {33'd0, mul_b};

    always_comb
    begin
        eff = CNT_W'(wcount_reg);
        if (wcount_reg == 3'd0)
            eff = CNT_W'(1);
        if ({1'b0, wcount_reg} > 4'(MAX_HISTORY))
            eff = CNT_W'(MAX_HISTORY);
    end

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_LOAD) || out_valid_reg;

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clamp_reg  <= 2'd0;
            wcount_reg <= 3'd6;
            for (int k = 0; k < 6; k++)
                weight_reg[k] <= 16'd256;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CLAMP: clamp_reg  <= cfg_data[1:0];
                REG_COUNT: wcount_reg <= cfg_data[2:0];
                default:
                begin
                    if (cfg_index >= REG_W0)
                        weight_reg[cfg_index - REG_W0] <= cfg_data;
                end
            endcase
        end
    end

    // Store accepted samples
    always_ff @(posedge clk)
    begin
        if (accept && count_reg < eff)
        begin
            value_store[count_reg[SLOT_W-1:0]] <= sample_value;
            time_store[count_reg[SLOT_W-1:0]]  <= sample_time;
        end
        if (accept)
            scale_reg <= scale_factor;
    end

    // Sample difference terms for the current pair
    logic [TIME_W-1:0] ti, tj;
    logic signed [VAL_W:0] dy;
    assign ti = time_store[i_reg];
    assign tj = time_store[j_reg];
    assign dy = $signed({value_store[i_reg][VAL_W-1], value_store[i_reg]})
              - $signed({value_store[j_reg][VAL_W-1], value_store[j_reg]});

    // Next state
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        limb_next  = limb_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    count_next = (count_reg < eff) ? count_reg + 1'b1 : count_reg;
                    if (is_last)
                    begin
                        n_next     = (count_next < eff) ? count_next : eff;
                        count_next = '0;
                        i_next     = '0;
                        j_next     = SLOT_W'(1);
                        state_next = (n_next < CNT_W'(2)) ? ST_OUT : ST_PAIR;
                    end
                end
            end
            ST_PAIR: state_next = ST_M1;
            ST_M1:   state_next = ST_M2;
            ST_M2:   state_next = ST_M3;
            ST_M3:   state_next = ST_ACC;
            ST_ACC:
            begin
                if (CNT_W'(j_reg) + 1'b1 < n_reg)
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_PAIR;
                end
                else if (CNT_W'(i_reg) + CNT_W'(2) < n_reg)
                begin
                    i_next     = i_reg + 1'b1;
                    j_next     = i_reg + SLOT_W'(2);
                    state_next = ST_PAIR;
                end
                else
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                if (den_reg == '0 || pos_reg == neg_reg)
                    state_next = ST_OUT;
                else if ((pos_reg > neg_reg) ? clamp_reg[0] : clamp_reg[1])
                    state_next = ST_OUT;
                else
                    state_next = ST_SC1;
            end
            ST_SC1:
            begin
                limb_next  = '0;
                state_next = ST_SC2;
            end
            ST_SC2:
            begin
                if (limb_reg == 3'(LIMB_N - 1))
                    state_next = ST_DSTART;
                else
                    limb_next = limb_reg + 1'b1;
            end
            ST_DSTART: state_next = ST_DIV;
            ST_DIV:  if (div_done) state_next = ST_OUT;
            ST_OUT:  if (!out_valid_reg) state_next = ST_LOAD;
            default: state_next = ST_LOAD;
        endcase
    end

    // Multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_M1:   begin mul_a = adx_reg; mul_b = wp_reg; end
            ST_M2:   begin mul_a = adx_reg; mul_b = prod_reg[31:0]; end
            ST_M3:   begin mul_a = ady_reg; mul_b = prod_reg[31:0]; end
            ST_SC1:  begin mul_a = 33'(HOUR_SECONDS); mul_b = 32'(scale_reg); end
            ST_SC2:  begin mul_a = {1'b0, divd_reg[ACC_W-1 -: 32]}; mul_b = prod_reg[31:0]; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // Products that are too wide for one pass use a second partial product
    logic [64:0] mul_hi;
    assign mul_hi = {32'd0, mul_a} * {33'd0, prod_reg[63:32]};

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_LOAD:
            begin
                pos_reg <= '0;
                neg_reg <= '0;
                den_reg <= '0;
            end
            ST_PAIR:
            begin
                adx_reg   <= (ti > tj) ? {1'b0, ti - tj} : {1'b0, tj - ti};
                ady_reg   <= dy[VAL_W] ? 33'(-dy) : 33'(dy);
                pneg_reg  <= (tj > ti) != dy[VAL_W];
                pzero_reg <= (ti == tj) || (dy == '0);
                wp_reg    <= weight_reg[i_reg] * weight_reg[j_reg];
            end
            // w*adx  (fits 65 bits)
            ST_M1: prod_reg <= ACC_W'(mul_p);
            // w*adx*adx
            ST_M2:
            begin
                tden_reg <= ACC_W'(mul_p) + (ACC_W'(mul_hi) << 32);
            end
            // w*adx*ady
            ST_M3:
            begin
                prod_reg <= ACC_W'(mul_p) + (ACC_W'(mul_hi) << 32);
            end
            ST_ACC:
            begin
                den_reg <= den_reg + tden_reg;
                if (!pzero_reg)
                begin
                    if (pneg_reg)
                        neg_reg <= neg_reg + prod_reg;
                    else
                        pos_reg <= pos_reg + prod_reg;
                end
            end
            ST_PREP:
            begin
                negr_reg <= neg_reg > pos_reg;
                divd_reg <= (neg_reg > pos_reg) ? neg_reg - pos_reg : pos_reg - neg_reg;
            end
            // 3600*scale into prod low word, clear the scaled numerator, shift den by 16
            ST_SC1:
            begin
                prod_reg <= ACC_W'(mul_p);
                den_reg  <= den_reg << 16;
                tden_reg <= '0;
            end
            // Scale the numerator one limb at a time, top limb first
            ST_SC2:
            begin
                tden_reg <= (tden_reg << 32) + ACC_W'(mul_p);
                divd_reg <= divd_reg << 32;
            end
            default: ;
        endcase
    end

    assign div_start = (state_reg == ST_DSTART);

    wts_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (tden_reg),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // Saturate the quotient
    logic              q_high;
    logic [RATE_W-1:0] rate_sat;
    logic              sat_flag;
    always_comb
    begin
        q_high   = quotient[QUO_W-1:RATE_W] != '0;
        rate_sat = '0;
        sat_flag = 1'b0;
        if (!negr_reg)
        begin
            if (q_high || quotient[RATE_W-1])
            begin
                rate_sat = {1'b0, {(RATE_W-1){1'b1}}};
                sat_flag = 1'b1;
            end
            else
                rate_sat = quotient[RATE_W-1:0];
        end
        else
        begin
            if (q_high || quotient[RATE_W-1:0] > {1'b1, {(RATE_W-1){1'b0}}})
            begin
                rate_sat = {1'b1, {(RATE_W-1){1'b0}}};
                sat_flag = 1'b1;
            end
            else
                rate_sat = RATE_W'(0) - quotient[RATE_W-1:0];
        end
    end

    // Control registers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            n_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            limb_reg      <= '0;
            out_valid_reg <= 1'b0;
            rate_reg      <= '0;
            degen_reg     <= 1'b0;
            sat_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            n_reg     <= n_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            limb_reg  <= limb_next;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            // Load a result from ST_LOAD for a single sample, from ST_PREP without a divide, or on divider done
            if (state_reg == ST_LOAD && accept && is_last && state_next == ST_OUT)
            begin
                out_valid_reg <= 1'b1;
                rate_reg      <= '0;
                degen_reg     <= 1'b1;
                sat_reg       <= 1'b0;
            end
            else if (state_reg == ST_PREP && state_next == ST_OUT)
            begin
                out_valid_reg <= 1'b1;
                rate_reg      <= '0;
                degen_reg     <= den_reg == '0;
                sat_reg       <= 1'b0;
            end
            else if (state_reg == ST_DIV && div_done)
            begin
                out_valid_reg <= 1'b1;
                rate_reg      <= rate_sat;
                degen_reg     <= 1'b0;
                sat_reg       <= sat_flag;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign rate_per_hour = rate_reg;
    assign degenerate    = degen_reg;
    assign saturated     = sat_reg;

    // Sample count never exceeds the store depth
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_HISTORY)) else $error("sample count overflow");
    // Pair indexes stay ordered while in the pair loop
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PAIR) |-> (j_reg > i_reg && CNT_W'(j_reg) < n_reg))
        else $error("pair index out of order");
    // A degenerate result carries zero rate
    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && degen_reg) |-> (rate_reg == '0 && !sat_reg))
        else $error("degenerate result with nonzero rate");

endmodule
